// File: hdl/rqs_pkg.sv
// Shared types, codes and helpers for the ready queue scheduler.
package rqs_pkg;

  localparam int unsigned DefTableDepth = 16;

  localparam logic [1:0] POL_RR   = 2'd0;
  localparam logic [1:0] POL_SRT  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  localparam logic [1:0] CFG_POLICY  = 2'd0;
  localparam logic [1:0] CFG_QUANTUM = 2'd1;
  localparam logic [1:0] CFG_CORES   = 2'd2;

  localparam logic [1:0] ST_ENQ  = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DISP = 2'd2;
  localparam logic [1:0] ST_NONE = 2'd3;

  localparam logic [7:0] QuantumReset = 8'd5;
  localparam logic [4:0] CoresReset   = 5'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT0,
    S_SHIFT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [7:0]  pid;
    logic [15:0] burst;
    logic [6:0]  prio;
    logic [8:0]  wait_cnt;
  } entry_t;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    entry_t      ent;
    logic [9:0]  thr;
  } alu_req_t;

  typedef struct packed {
    logic        lt;
    entry_t      aged;
    logic [7:0]  slice;
    logic [15:0] rem;
  } alu_rsp_t;

  // twenty times the core count
  function automatic logic [9:0] age_threshold(input logic [4:0] cores);
    age_threshold = {1'b0, cores, 4'b0000} + {3'b000, cores, 2'b00};
  endfunction

endpackage

// File: hdl/rqs_table.sv
// Ready table storage: one write port, one registered read port.
module rqs_table
  import rqs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] waddr_i,
  input  entry_t                         wdata_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] raddr_i,
  output entry_t                         rdata_o
);

  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/rqs_alu.sv
// Shared compare unit with aging update and slice split.
module rqs_alu
  import rqs_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  always_comb begin
    rsp_o.lt    = req_i.a < req_i.b;
    rsp_o.slice = rsp_o.lt ? req_i.a[7:0] : req_i.b[7:0];
    rsp_o.rem   = req_i.b - {8'd0, rsp_o.slice};
    rsp_o.aged  = req_i.ent;
    if ({1'b0, req_i.ent.wait_cnt} == req_i.thr) begin
      if (req_i.ent.prio > 7'd1) begin
        rsp_o.aged.prio     = req_i.ent.prio - 7'd1;
        rsp_o.aged.wait_cnt = 9'd0;
      end
    end else begin
      rsp_o.aged.wait_cnt = req_i.ent.wait_cnt + 9'd1;
    end
  end

endmodule

// File: hdl/ready_queue_cpu_scheduler.sv
// Ready queue CPU scheduler top level: sequencer, configuration and result register.
// An enqueue, or a dispatch that finds no free core or an empty table, is done in the
// idle state and returns its result at once. A dispatch with N queued entries, choosing
// entry S, makes one pass over the table through its single read port, feeding the
// shared compare unit one entry a cycle (and writing back aged entries under the
// priority policy), then moves each entry above S down to close the gap, then splits the
// slice, waiting for a free result register. The block accepts nothing while a dispatch
// is in progress. The result register lets a new item in while the last result is taken.
module ready_queue_cpu_scheduler
  import rqs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        mode_i,
  input  logic [7:0]  proc_id_i,
  input  logic [15:0] burst_i,
  input  logic [6:0]  prio_i,
  input  logic        core_free_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  out_proc_id_o,
  output logic [7:0]  slice_o,
  output logic [15:0] remainder_o,
  output logic [6:0]  out_prio_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  state_e        state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] sel_q, sel_d;
  logic [15:0]   best_key_q, best_key_d;
  logic [7:0]    best_pid_q, best_pid_d;
  logic [15:0]   best_burst_q, best_burst_d;
  logic [6:0]    best_prio_q, best_prio_d;

  logic [1:0]    policy_q;
  logic [7:0]    quantum_q;
  logic [4:0]    cores_q;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    status_q, status_d;
  logic [7:0]    opid_q, opid_d;
  logic [7:0]    slice_q, slice_d;
  logic [15:0]   rem_q, rem_d;
  logic [6:0]    oprio_q, oprio_d;

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        wdata;
  entry_t        rd_data;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  logic          out_free;
  logic          in_fire;
  logic          ranked;
  logic [15:0]   key;

  rqs_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rd_data)
  );

  rqs_alu u_alu (
    .req_i(alu_req),
    .rsp_o(alu_rsp)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;
  assign ranked     = (policy_q == POL_SRT) || (policy_q == POL_PRIO);
  assign key        = (policy_q == POL_SRT) ? rd_data.burst : {9'd0, rd_data.prio};

  always_comb begin
    alu_req.ent = rd_data;
    alu_req.thr = age_threshold(cores_q);
    if (state_q == S_FIN) begin
      alu_req.a = {8'd0, quantum_q};
      alu_req.b = best_burst_q;
    end else begin
      alu_req.a = key;
      alu_req.b = best_key_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    sel_d        = sel_q;
    best_key_d   = best_key_q;
    best_pid_d   = best_pid_q;
    best_burst_d = best_burst_q;
    best_prio_d  = best_prio_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    opid_d       = opid_q;
    slice_d      = slice_q;
    rem_d        = rem_q;
    oprio_d      = oprio_q;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = rd_data;
    raddr        = idx_q + AW'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (!mode_i) begin
            out_valid_d = 1'b1;
            opid_d      = 8'd0;
            slice_d     = 8'd0;
            rem_d       = 16'd0;
            oprio_d     = 7'd0;
            if (cnt_q == CW'(TABLE_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              status_d = ST_ENQ;
              we       = 1'b1;
              waddr    = AW'(cnt_q);
              wdata    = '{pid: proc_id_i, burst: burst_i, prio: prio_i, wait_cnt: 9'd0};
              cnt_d    = cnt_q + CW'(1);
            end
          end else if (!core_free_i || (cnt_q == '0)) begin
            out_valid_d = 1'b1;
            status_d    = ST_NONE;
            opid_d      = 8'd0;
            slice_d     = 8'd0;
            rem_d       = 16'd0;
            oprio_d     = 7'd0;
          end else begin
            raddr   = '0;
            idx_d   = '0;
            sel_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if ((idx_q == '0) || (ranked && alu_rsp.lt)) begin
          sel_d        = idx_q;
          best_key_d   = key;
          best_pid_d   = rd_data.pid;
          best_burst_d = rd_data.burst;
          best_prio_d  = rd_data.prio;
        end
        if (policy_q == POL_PRIO) begin
          we    = 1'b1;
          waddr = idx_q;
          wdata = alu_rsp.aged;
        end
        if (CW'(idx_q) + CW'(1) == cnt_q) begin
          state_d = S_SHIFT0;
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      S_SHIFT0: begin
        if (CW'(sel_q) + CW'(1) == cnt_q) begin
          state_d = S_FIN;
        end else begin
          raddr   = sel_q + AW'(1);
          idx_d   = sel_q;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = idx_q;
        wdata = rd_data;
        if (CW'(idx_q) + CW'(2) == cnt_q) begin
          state_d = S_FIN;
        end else begin
          raddr = AW'(CW'(idx_q) + CW'(2));
          idx_d = idx_q + AW'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = ST_DISP;
          opid_d      = best_pid_q;
          slice_d     = alu_rsp.slice;
          rem_d       = alu_rsp.rem;
          oprio_d     = best_prio_q;
          cnt_d       = cnt_q - CW'(1);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      policy_q    <= POL_RR;
      quantum_q   <= QuantumReset;
      cores_q     <= CoresReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_POLICY:  policy_q  <= cfg_wdata_i[1:0];
          CFG_QUANTUM: quantum_q <= cfg_wdata_i;
          CFG_CORES:   cores_q   <= cfg_wdata_i[4:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    sel_q        <= sel_d;
    best_key_q   <= best_key_d;
    best_pid_q   <= best_pid_d;
    best_burst_q <= best_burst_d;
    best_prio_q  <= best_prio_d;
    status_q     <= status_d;
    opid_q       <= opid_d;
    slice_q      <= slice_d;
    rem_q        <= rem_d;
    oprio_q      <= oprio_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_proc_id_o = opid_q;
  assign slice_o       = slice_q;
  assign remainder_o   = rem_q;
  assign out_prio_o    = oprio_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !mode_i && (cnt_q == CW'(TABLE_DEPTH)))
    |=> (out_valid_o && (status_o == ST_FULL) && (cnt_q == $past(cnt_q))))
    else $error("enqueue into full table not dropped");

  a_disp_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_FIN) && out_free)
    |=> (out_valid_o && (status_o == ST_DISP) && (cnt_q == $past(cnt_q) - CW'(1))))
    else $error("dispatch did not remove one entry");

endmodule

// File: bench/ready_queue_checker.sv
`timescale 1ns / 1ps
// Ready queue scheduler checker: mirrors the ready table and compares every result.
module ready_queue_checker
  import rqs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = DefTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        mode_i,
  input  logic [7:0]  proc_id_i,
  input  logic [15:0] burst_i,
  input  logic [6:0]  prio_i,
  input  logic        core_free_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [7:0]  out_proc_id_i,
  input  logic [7:0]  slice_i,
  input  logic [15:0] remainder_i,
  input  logic [6:0]  out_prio_i,
  output int          mismatches_o,
  output int          pending_o,
  output int          full_drops_o,
  output int          grants_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  pid;
    logic [7:0]  slice;
    logic [15:0] rem;
    logic [6:0]  prio;
  } sched_result_t;

  entry_t        ready_tbl [TABLE_DEPTH];
  int unsigned   ready_cnt;
  logic [1:0]    policy_q;
  logic [7:0]    quantum_q;
  logic [4:0]    cores_q;
  sched_result_t dispatch_q [$];
  int            mismatch_cnt;
  int            drop_cnt;
  int            grant_cnt;

  function automatic sched_result_t schedule_item(input logic mode, input logic [7:0] pid,
                                                  input logic [15:0] burst,
                                                  input logic [6:0] prio,
                                                  input logic core_free);
    sched_result_t res;
    int unsigned   sel;
    logic [6:0]    best_prio;
    logic [9:0]    thr;
    logic [15:0]   sel_burst;
    res = '0;
    if (mode == 1'b0) begin
      if (ready_cnt >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        ready_tbl[ready_cnt].pid      = pid;
        ready_tbl[ready_cnt].burst    = burst;
        ready_tbl[ready_cnt].prio     = prio;
        ready_tbl[ready_cnt].wait_cnt = '0;
        ready_cnt++;
        res.status = ST_ENQ;
      end
      return res;
    end
    if (!core_free || ready_cnt == 0) begin
      res.status = ST_NONE;
      return res;
    end
    sel = 0;
    best_prio = ready_tbl[0].prio;
    thr = {5'b00000, cores_q} * 10'd20;
    if (policy_q == POL_SRT) begin
      for (int unsigned i = 1; i < ready_cnt; i++) begin
        if (ready_tbl[i].burst < ready_tbl[sel].burst) sel = i;
      end
    end else if (policy_q == POL_PRIO) begin
      // compare on the priority held before this pass ages the entry
      for (int unsigned i = 0; i < ready_cnt; i++) begin
        if (i > 0 && ready_tbl[i].prio < best_prio) begin
          best_prio = ready_tbl[i].prio;
          sel = i;
        end
        if ({1'b0, ready_tbl[i].wait_cnt} == thr) begin
          if (ready_tbl[i].prio > 7'd1) begin
            ready_tbl[i].prio     = ready_tbl[i].prio - 7'd1;
            ready_tbl[i].wait_cnt = '0;
          end
        end else begin
          ready_tbl[i].wait_cnt = ready_tbl[i].wait_cnt + 9'd1;
        end
      end
    end
    sel_burst  = ready_tbl[sel].burst;
    res.status = ST_DISP;
    res.pid    = ready_tbl[sel].pid;
    res.prio   = (policy_q == POL_PRIO) ? best_prio : ready_tbl[sel].prio;
    res.slice  = (sel_burst > {8'h00, quantum_q}) ? quantum_q : sel_burst[7:0];
    res.rem    = sel_burst - {8'h00, res.slice};
    for (int unsigned i = sel; i + 1 < ready_cnt; i++) ready_tbl[i] = ready_tbl[i + 1];
    ready_cnt--;
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    sched_result_t want;
    if (!rst_ni) begin
      ready_cnt    = 0;
      policy_q     = POL_RR;
      quantum_q    = QuantumReset;
      cores_q      = CoresReset;
      mismatch_cnt = 0;
      drop_cnt     = 0;
      grant_cnt    = 0;
      dispatch_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_POLICY:  policy_q  = cfg_wdata_i[1:0];
          CFG_QUANTUM: quantum_q = cfg_wdata_i;
          CFG_CORES:   cores_q   = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (dispatch_q.size() == 0) begin
          $error("unexpected result transaction, status %0d", status_i);
          mismatch_cnt++;
        end else begin
          want = dispatch_q.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("out_proc_id", 32'(want.pid), 32'(out_proc_id_i));
          check_field("slice", 32'(want.slice), 32'(slice_i));
          check_field("remainder", 32'(want.rem), 32'(remainder_i));
          check_field("out_prio", 32'(want.prio), 32'(out_prio_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        want = schedule_item(mode_i, proc_id_i, burst_i, prio_i, core_free_i);
        if (want.status == ST_FULL) drop_cnt++;
        if (want.status == ST_DISP) grant_cnt++;
        dispatch_q.push_back(want);
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= dispatch_q.size();
    full_drops_o <= drop_cnt;
    grants_o     <= grant_cnt;
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Ready queue scheduler testbench top: clock, reset, stimulus, result sink and verdict.
module testbench;
  import rqs_pkg::*;

  localparam int unsigned Depth      = DefTableDepth;
  localparam int          CycleLimit = 500000;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = CFG_POLICY;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic        mode_i      = 1'b0;
  logic [7:0]  proc_id_i   = '0;
  logic [15:0] burst_i     = 16'd1;
  logic [6:0]  prio_i      = 7'd1;
  logic        core_free_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  out_proc_id_o;
  logic [7:0]  slice_o;
  logic [15:0] remainder_o;
  logic [6:0]  out_prio_o;

  int   mismatches;
  int   pending;
  int   full_drops;
  int   grants;
  int   cycle_cnt    = 0;
  int   enq_sent     = 0;
  int   disp_sent    = 0;
  int   settings_cnt = 0;
  logic idle_on      = 1'b1;

  ready_queue_cpu_scheduler #(.TABLE_DEPTH(Depth)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .mode_i, .proc_id_i, .burst_i, .prio_i, .core_free_i,
    .out_valid_o, .out_ready_i, .status_o, .out_proc_id_o, .slice_o, .remainder_o,
    .out_prio_o
  );

  ready_queue_checker #(.TABLE_DEPTH(Depth)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .proc_id_i, .burst_i, .prio_i,
    .core_free_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .out_proc_id_i(out_proc_id_o), .slice_i(slice_o), .remainder_i(remainder_o),
    .out_prio_i(out_prio_o), .mismatches_o(mismatches), .pending_o(pending),
    .full_drops_o(full_drops), .grants_o(grants)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("** ready_queue_cpu_scheduler: FAILED **");
    $finish;
  end

  task automatic offer_item(input logic mode, input logic [7:0] pid, input logic [15:0] burst,
                            input logic [6:0] prio, input logic core_free);
    int gap;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    mode_i      <= mode;
    proc_id_i   <= pid;
    burst_i     <= burst;
    prio_i      <= prio;
    core_free_i <= core_free;
    do @(posedge clk_i); while (!in_ready_o);
    if (mode) disp_sent++;
    else enq_sent++;
  endtask

  // drop valid and hold until every expected result has been taken
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_config(input logic [1:0] policy, input logic [7:0] quantum,
                              input logic [4:0] cores);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_POLICY;
    cfg_wdata_i <= {6'b000000, policy};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_QUANTUM;
    cfg_wdata_i <= quantum;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CORES;
    cfg_wdata_i <= {3'b000, cores};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    settings_cnt++;
  endtask

  task automatic run_phase(input int n_items);
    int          enq_pct;
    logic        mode;
    logic [15:0] burst;
    logic [6:0]  prio;
    for (int k = 0; k < n_items; k++) begin
      if (k % 50 == 0) begin
        enq_pct = $urandom_range(30, 70);
        idle_on <= ($urandom_range(0, 9) < 7);
      end
      mode = ($urandom_range(0, 99) >= enq_pct);
      case ($urandom_range(0, 3))
        0: burst = 16'($urandom_range(1, 65535));
        1: burst = 16'($urandom_range(1, 8));
        default: burst = 16'($urandom_range(1, 300));
      endcase
      if ($urandom_range(0, 2) == 0) prio = 7'($urandom_range(1, 127));
      else prio = 7'($urandom_range(1, 4));
      offer_item(mode, 8'($urandom), burst, prio, $urandom_range(0, 9) != 0);
    end
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (taken == 200 || taken == 800) begin
        out_ready_i <= 1'b0;
        repeat (250) @(posedge clk_i);
      end else begin
        stall = idle_on ? $urandom_range(0, 10) : 0;
        if (stall > 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin : stimulus
    logic [15:0] burst;
    logic [6:0]  prio;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_config(POL_RR, 8'd1, 5'd1);
    offer_item(1'b1, 8'h00, 16'd1, 7'd1, 1'b1);
    for (int k = 0; k < 16; k++) begin
      if (k == 0) burst = 16'd1;
      else if (k == 1) burst = 16'hFFFF;
      else if (k == 4 || k == 9) burst = 16'd2;
      else burst = (k % 2 == 1) ? 16'hAAAA : 16'h5555;
      if (k == 1) prio = 7'd127;
      else if (k == 12) prio = 7'd1;
      else if (k == 3 || k == 7) prio = 7'd2;
      else prio = (k % 2 == 1) ? 7'h55 : 7'h2A;
      offer_item(1'b0, (k == 15) ? 8'hFF : 8'(k * 16), burst, prio, k % 2 == 1);
    end
    offer_item(1'b0, 8'h77, 16'd9, 7'd9, 1'b1);
    offer_item(1'b1, 8'h00, 16'd1, 7'd1, 1'b0);
    offer_item(1'b1, 8'h00, 16'd1, 7'd1, 1'b1);
    write_config(POL_SRT, 8'd255, 5'd16);
    repeat (2) offer_item(1'b1, 8'hFF, 16'hFFFF, 7'd127, 1'b1);
    write_config(POL_PRIO, 8'd200, 5'd1);
    repeat (2) offer_item(1'b1, 8'h5A, 16'h00FF, 7'h7F, 1'b1);

    write_config(POL_RR, 8'd5, 5'd1);
    run_phase(150);
    write_config(POL_SRT, 8'd255, 5'd16);
    run_phase(200);
    write_config(POL_PRIO, 8'd1, 5'd1);
    run_phase(300);
    write_config(POL_PRIO, 8'd255, 5'd16);
    run_phase(300);
    write_config(POL_SRT, 8'd1, 5'd7);
    run_phase(150);
    write_config(POL_RR, 8'd255, 5'd16);
    run_phase(100);
    write_config(POL_PRIO, 8'($urandom_range(1, 255)), 5'($urandom_range(1, 16)));
    run_phase(100);

    settle();
    repeat (2 * Depth + 8) @(posedge clk_i);
    $display("Run covered %0d enqueue and %0d dispatch transactions under %0d register settings.",
             enq_sent, disp_sent, settings_cnt);
    $display("Cores granted %0d processes; %0d enqueues were dropped on a full table.",
             grants, full_drops);
    if (mismatches == 0) begin
      $display("** ready_queue_cpu_scheduler: PASSED **");
    end else begin
      $display("** ready_queue_cpu_scheduler: FAILED **");
    end
    $finish;
  end

endmodule
